### rtl/scan_code_to_ascii_translator_unit_defines.svh
// Assertion macros for the scan code translator RTL.
`ifndef SCAN_CODE_TO_ASCII_TRANSLATOR_UNIT_DEFINES_SVH
`define SCAN_CODE_TO_ASCII_TRANSLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SC2A_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sc2a: assertion failed");

// Next-cycle implication, disabled during reset.
`define SC2A_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sc2a: assertion failed");

`endif

### rtl/sc2a_pkg.sv
// Types, codes and character tables for the scan code translator.
package sc2a_pkg;

  typedef enum logic [2:0] {
    KIND_PREFIX     = 3'd0,
    KIND_FUNCTIONAL = 3'd1,
    KIND_RELEASED   = 3'd2,
    KIND_PRINTABLE  = 3'd3,
    KIND_OTHER      = 3'd4
  } key_kind_t;

  // One table row: plain, shifted and AltGr/extended columns.
  typedef struct packed {
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } char_row_t;

  localparam logic [7:0] NP          = 8'h00;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_BTICK    = 8'h60;

  localparam logic [7:0] SC_PREFIX   = 8'hE0;
  localparam logic [6:0] KC_TAB      = 7'h0F;
  localparam logic [6:0] KC_CTRL     = 7'h1D;
  localparam logic [6:0] KC_LSHIFT   = 7'h2A;
  localparam logic [6:0] KC_RSHIFT   = 7'h36;
  localparam logic [6:0] KC_ALT      = 7'h38;
  localparam logic [6:0] KC_CAPS     = 7'h3A;
  localparam logic [6:0] KC_NUMLOCK  = 7'h45;
  localparam logic [6:0] KC_PAD_LO   = 7'd71;
  localparam logic [6:0] KC_PAD_HI   = 7'd83;

  function automatic char_row_t mk(input logic [7:0] c0, input logic [7:0] c1,
                                   input logic [7:0] c2);
    char_row_t r;
    r.c0 = c0;
    r.c1 = c1;
    r.c2 = c2;
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
  endfunction

  // layout 0: Spanish, layout 1: English.
  function automatic char_row_t char_row(input logic layout, input logic [6:0] code);
    char_row_t r;
    r = '0;
    case (code)
      7'd2:  r = mk("1", "!", NP);
      7'd3:  r = layout ? mk("2", "@", NP) : mk("2", CH_DQUOTE, "@");
      7'd4:  r = mk("3", "#", NP);
      7'd5:  r = mk("4", "$", NP);
      7'd6:  r = mk("5", "%", NP);
      7'd7:  r = layout ? mk("6", "^", NP) : mk("6", "&", NP);
      7'd8:  r = layout ? mk("7", "&", NP) : mk("7", "/", NP);
      7'd9:  r = layout ? mk("8", "*", NP) : mk("8", "(", NP);
      7'd10: r = layout ? mk("9", "(", NP) : mk("9", ")", NP);
      7'd11: r = layout ? mk("0", ")", NP) : mk("0", "=", NP);
      7'd12: r = layout ? mk("-", "_", NP) : mk(CH_SQUOTE, "?", NP);
      7'd13: r = layout ? mk("=", "+", NP) : mk(NP, NP, NP);
      7'd14: r = mk(CH_BS, CH_BS, NP);
      7'd16: r = mk("q", "Q", NP);
      7'd17: r = mk("w", "W", NP);
      7'd18: r = mk("e", "E", NP);
      7'd19: r = mk("r", "R", NP);
      7'd20: r = mk("t", "T", NP);
      7'd21: r = mk("y", "Y", NP);
      7'd22: r = mk("u", "U", NP);
      7'd23: r = mk("i", "I", NP);
      7'd24: r = mk("o", "O", NP);
      7'd25: r = mk("p", "P", NP);
      7'd26: r = layout ? mk("[", "{", NP) : mk(CH_BTICK, "^", NP);
      7'd27: r = layout ? mk("]", "}", NP) : mk("+", "*", NP);
      7'd28: r = mk(CH_LF, CH_LF, CH_LF);
      7'd30: r = mk("a", "A", NP);
      7'd31: r = mk("s", "S", NP);
      7'd32: r = mk("d", "D", NP);
      7'd33: r = mk("f", "F", NP);
      7'd34: r = mk("g", "G", NP);
      7'd35: r = mk("h", "H", NP);
      7'd36: r = mk("j", "J", NP);
      7'd37: r = mk("k", "K", NP);
      7'd38: r = mk("l", "L", NP);
      7'd39: r = layout ? mk(";", ":", NP) : mk(":", ";", NP);
      7'd40: r = layout ? mk(CH_SQUOTE, CH_DQUOTE, NP) : mk("{", "[", NP);
      7'd41: r = layout ? mk(CH_BTICK, "~", NP) : mk(CH_BSLASH, CH_BSLASH, NP);
      7'd43: r = layout ? mk(CH_BSLASH, "|", NP) : mk("}", "]", NP);
      7'd44: r = mk("z", "Z", NP);
      7'd45: r = mk("x", "X", NP);
      7'd46: r = mk("c", "C", NP);
      7'd47: r = mk("v", "V", NP);
      7'd48: r = mk("b", "B", NP);
      7'd49: r = mk("n", "N", NP);
      7'd50: r = mk("m", "M", NP);
      7'd51: r = layout ? mk(",", "<", NP) : mk(",", ";", NP);
      7'd52: r = layout ? mk(".", ">", NP) : mk(".", ":", NP);
      7'd53: r = layout ? mk("/", "?", "/") : mk("-", "_", "/");
      7'd55: r = mk("*", "*", NP);
      7'd57: r = mk(" ", " ", NP);
      7'd71: r = mk(NP, "7", NP);
      7'd72: r = mk(NP, "8", NP);
      7'd73: r = mk(NP, "9", NP);
      7'd74: r = mk("-", "-", NP);
      7'd75: r = mk(NP, "4", NP);
      7'd76: r = mk(NP, "5", NP);
      7'd77: r = mk(NP, "6", NP);
      7'd78: r = mk("+", "+", NP);
      7'd79: r = mk(NP, "1", NP);
      7'd80: r = mk(NP, "2", NP);
      7'd81: r = mk(NP, "3", NP);
      7'd82: r = mk(NP, "0", NP);
      7'd83: r = mk(NP, ".", NP);
      7'd85: r = mk("+", "*", NP);
      7'd86: r = layout ? mk(CH_BSLASH, "|", NP) : mk("<", ">", NP);
      7'd89: r = mk("+", "*", NP);
      7'd90: r = mk("+", "*", NP);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/scan_code_to_ascii_translator_unit.sv
// Top level of the set-1 scan code to ASCII translator.
//
// Usage:
//   Request channel: scan_valid / scan_ready / scan_code carry one raw set-1
//   byte per request. Result channel: key_valid / key_ready with key_kind
//   and key_value carry exactly one classified key per request, in order.
//   Config: APB-style port; register 0 (byte address 0) is layout_select,
//   0 Spanish table, 1 English table. Write it only while the block is idle.
// Path: the ROM read and flag capture are registered at the accepting edge;
//   the output register then loads the result and raises key_valid once the
//   output can advance.
// Throughput: one request per cycle while key_ready keeps the output moving;
//   the character ROM read is the only lookup stage, flags update at accept.
// Reset: synchronous, active high. Clears both pipeline valids, shift,
//   AltGr, caps lock and extended prefix; num lock comes up on; layout 0.
// Stall: while key_ready is low the output register holds its key; one more
//   request can still be taken into the ROM stage, after which scan_ready
//   drops until the output moves.
`include "scan_code_to_ascii_translator_unit_defines.svh"

module scan_code_to_ascii_translator_unit #(
  parameter int TABLE_ENTRIES = 91,
  parameter int LAYOUTS       = 2
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        scan_valid,
  output logic        scan_ready,
  input  logic [7:0]  scan_code,
  // result channel
  output logic        key_valid,
  input  logic        key_ready,
  output logic [2:0]  key_kind,
  output logic [7:0]  key_value
);

  // What stage 0 decided about a request before the table lookup.
  typedef enum logic [1:0] {
    CLS_PREFIX,
    CLS_FUNCTIONAL,
    CLS_RELEASED,
    CLS_LOOKUP
  } class_t;

  // ---- config register ----
  logic layout_select;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == 1'b0);
  assign prdata  = cfg_hit ? {31'b0, layout_select} : 32'b0;

  // ---- handshakes ----
  logic accept;
  logic advance;
  logic s1_valid;

  assign advance    = !key_valid || key_ready;
  assign scan_ready = !s1_valid || advance;
  assign accept     = scan_valid && scan_ready;

  // ---- keyboard state ----
  logic ext_pending, shift_down, altgr_down, caps_on, keypad_digits_on;
  logic ext_pending_next, shift_down_next, altgr_down_next;
  logic caps_on_next, keypad_digits_on_next;

  // ---- stage 0: decode ----
  logic       make;
  logic [6:0] code;
  logic       functional;
  class_t     cls;

  assign make = !scan_code[7];
  assign code = scan_code[6:0];

  always_comb begin
    shift_down_next       = shift_down;
    altgr_down_next       = altgr_down;
    caps_on_next          = caps_on;
    keypad_digits_on_next = keypad_digits_on;
    ext_pending_next      = 1'b0;
    functional            = 1'b0;
    if (scan_code == sc2a_pkg::SC_PREFIX) begin
      ext_pending_next = 1'b1;
    end else if (ext_pending) begin
      // after a prefix only right alt (AltGr) is a modifier
      if (code == sc2a_pkg::KC_ALT) begin
        functional      = 1'b1;
        altgr_down_next = make;
      end
    end else begin
      case (code)
        sc2a_pkg::KC_CTRL, sc2a_pkg::KC_ALT: begin
          functional = 1'b1;
        end
        sc2a_pkg::KC_LSHIFT, sc2a_pkg::KC_RSHIFT: begin
          functional      = 1'b1;
          shift_down_next = make;
        end
        sc2a_pkg::KC_CAPS: begin
          functional   = 1'b1;
          caps_on_next = caps_on ^ make;
        end
        sc2a_pkg::KC_NUMLOCK: begin
          functional            = 1'b1;
          keypad_digits_on_next = keypad_digits_on ^ make;
        end
        sc2a_pkg::KC_TAB: begin
          functional = make;    // tab break falls through to release
        end
        default: begin
          functional = 1'b0;
        end
      endcase
    end

    if (scan_code == sc2a_pkg::SC_PREFIX) begin
      cls = CLS_PREFIX;
    end else if (functional) begin
      cls = CLS_FUNCTIONAL;
    end else if (!make) begin
      cls = CLS_RELEASED;      // includes 0x80 as release of code 0
    end else begin
      cls = CLS_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_select    <= 1'b0;
      ext_pending      <= 1'b0;
      shift_down       <= 1'b0;
      altgr_down       <= 1'b0;
      caps_on          <= 1'b0;
      keypad_digits_on <= 1'b1;
    end else begin
      if (psel && penable && pwrite && cfg_hit) begin
        layout_select <= pwdata[0];
      end
      if (accept) begin
        ext_pending      <= ext_pending_next;
        shift_down       <= shift_down_next;
        altgr_down       <= altgr_down_next;
        caps_on          <= caps_on_next;
        keypad_digits_on <= keypad_digits_on_next;
      end
    end
  end

  // ---- stage 1: table read in flight ----
  // Lookup uses the flags as they stood before this request (captured at
  // accept), so no forwarding is needed; a lookup only clears ext_pending.
  class_t              s1_cls;
  logic [7:0]          s1_raw;
  logic                s1_col2;
  logic                s1_kp;
  logic                s1_shift;
  logic                s1_caps;
  sc2a_pkg::char_row_t rom_row;

  sc2a_char_rom #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LAYOUTS      (LAYOUTS)
  ) u_rom (
    .clk   (clk),
    .rd_en (accept),
    .layout(layout_select),
    .code  (code),
    .row   (rom_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_ready) begin
      s1_valid <= scan_valid;
    end
    if (accept) begin
      s1_cls   <= cls;
      s1_raw   <= scan_code;
      s1_col2  <= altgr_down || ext_pending;
      s1_kp    <= keypad_digits_on;
      s1_shift <= shift_down;
      s1_caps  <= caps_on;
    end
  end

  // ---- column pick and result ----
  logic [6:0] s1_code;
  logic [7:0] ch_shift;
  logic [7:0] ch;
  logic [2:0] res_kind;
  logic [7:0] res_value;

  assign s1_code  = s1_raw[6:0];
  assign ch_shift = s1_shift ? rom_row.c1 : rom_row.c0;

  always_comb begin
    if (s1_col2) begin
      ch = rom_row.c2;
    end else if ((s1_code >= sc2a_pkg::KC_PAD_LO) && (s1_code <= sc2a_pkg::KC_PAD_HI)) begin
      ch = s1_kp ? rom_row.c1 : rom_row.c0;
    end else if (sc2a_pkg::is_letter(ch_shift)) begin
      ch = (s1_shift ^ s1_caps) ? rom_row.c1 : rom_row.c0;
    end else begin
      ch = ch_shift;
    end

    case (s1_cls)
      CLS_PREFIX: begin
        res_kind  = sc2a_pkg::KIND_PREFIX;
        res_value = 8'h00;
      end
      CLS_FUNCTIONAL: begin
        res_kind  = sc2a_pkg::KIND_FUNCTIONAL;
        res_value = {1'b0, s1_code};
      end
      CLS_RELEASED: begin
        res_kind  = sc2a_pkg::KIND_RELEASED;
        res_value = s1_raw;
      end
      default: begin
        if (ch != sc2a_pkg::NP) begin
          res_kind  = sc2a_pkg::KIND_PRINTABLE;
          res_value = ch;
        end else begin
          res_kind  = sc2a_pkg::KIND_OTHER;
          res_value = {1'b0, s1_code};
        end
      end
    endcase
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (advance) begin
      key_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      key_kind  <= res_kind;
      key_value <= res_value;
    end
  end

  // ---- assertions ----
  `SC2A_ASSERT_NEXT(a_prefix_sets_pending, clk, rst,
    accept && (scan_code == sc2a_pkg::SC_PREFIX), ext_pending)
  `SC2A_ASSERT_NEXT(a_other_clears_pending, clk, rst,
    accept && (scan_code != sc2a_pkg::SC_PREFIX), !ext_pending)
  `SC2A_ASSERT_NEXT(a_caps_toggles, clk, rst,
    accept && !ext_pending && (scan_code == {1'b0, sc2a_pkg::KC_CAPS}),
    caps_on != $past(caps_on))
  `SC2A_ASSERT_IMPL(a_printable_nonzero, clk, rst,
    key_valid && (key_kind == sc2a_pkg::KIND_PRINTABLE), key_value != 8'h00)

endmodule

### rtl/sc2a_char_rom.sv
// Character table ROM with registered read, one row per key code.
module sc2a_char_rom #(
  parameter int TABLE_ENTRIES = 91,
  parameter int LAYOUTS       = 2
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic                  layout,
  input  logic [6:0]            code,
  output sc2a_pkg::char_row_t   row
);

  localparam bit MultiLayout = (LAYOUTS > 1);
  localparam logic [7:0] CodeLimit = 8'(TABLE_ENTRIES);

  logic lay;

  assign lay = MultiLayout ? layout : 1'b0;

  // Codes past the table read as an empty row.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if ({1'b0, code} < CodeLimit) begin
        row <= sc2a_pkg::char_row(lay, code);
      end else begin
        row <= '0;
      end
    end
  end

endmodule
